FILE: src/chained_hash_find_or_insert_assert.svh
// Assertion macros shared by the chained hash find-or-insert RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHAINED_HASH_FIND_OR_INSERT_ASSERT_SVH
`define CHAINED_HASH_FIND_OR_INSERT_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define CHFI_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("chfi assertion failed");
// Next-cycle implication, checked outside reset.
`define CHFI_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("chfi assertion failed");
`endif

FILE: src/chfi_pkg.sv
// Package for the chained hash find-or-insert block: sizes and state types.
// Depends on nothing.
`default_nettype none
package chfi_pkg;
  localparam int DEF_BUCKETS      = 256;
  localparam int DEF_POOL_ENTRIES = 1024;
  localparam int CODE_W           = 16;
  localparam int BITS_PER_STEP    = 4;
  localparam int DIV_STEPS        = CODE_W / BITS_PER_STEP;
  localparam int CFG_W            = 9;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_HEAD, B_READ, B_CMP, B_DONE} back_state_t;
endpackage
`default_nettype wire

FILE: src/chfi_front.sv
// Front part: accepts items and works out the bucket by iterative modulo.
// Depends on chfi_pkg.
`default_nettype none
module chfi_front #(
  parameter int BUCKETS = 256,
  parameter int HW = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        kind,
  input  wire logic [chfi_pkg::CODE_W-1:0] char_code,
  input  wire logic [chfi_pkg::CFG_W-1:0]  bucket_count,
  output logic                             q_push,
  input  wire logic                        q_full,
  output logic [HW+chfi_pkg::CODE_W:0]     q_data
);
  import chfi_pkg::*;
  localparam int DW = $clog2(BUCKETS + 1);
  localparam int SW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  front_state_t     state, state_next;
  logic             clr;
  logic [CODE_W-1:0] code, shf, shf_next;
  logic [DW-1:0]    dvs, rem, rem_next, dvs_in;
  logic [SW-1:0]    cnt;
  logic [HW-1:0]    bkt;
  logic [DW:0]      t;

  always_comb begin
    if (bucket_count == '0) begin
      dvs_in = DW'(1);
    end else if (32'(bucket_count) > 32'(BUCKETS)) begin
      dvs_in = DW'(BUCKETS);
    end else begin
      dvs_in = DW'(bucket_count);
    end
  end

  // Four restoring-division steps per cycle on the remainder.
  always_comb begin
    rem_next = rem;
    shf_next = shf;
    t = '0;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      t = {rem_next, shf_next[CODE_W-1]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      rem_next = DW'(t);
      shf_next = {shf_next[CODE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_next = state;
    full = (state != F_IDLE);
    q_push = 1'b0;
    case (state)
      F_IDLE: if (push) state_next = F_DIV;
      F_DIV:  if (cnt == SW'(DIV_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: begin
        q_push = !q_full;
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign q_data = {clr, code, bkt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      clr  <= kind;
      code <= char_code;
      shf  <= char_code;
      dvs  <= dvs_in;
      rem  <= '0;
      cnt  <= '0;
    end else if (state == F_DIV) begin
      rem <= rem_next;
      shf <= shf_next;
      cnt <= cnt + SW'(1);
      if (cnt == SW'(DIV_STEPS - 1)) begin
        bkt <= HW'(rem_next);
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/chfi_queue.sv
// Two-entry queue between the front and back parts.
// Depends on nothing; the entry width is set by its parameter W.
`default_nettype none
module chfi_queue #(
  parameter int W = 25
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  output logic              q_full,
  input  wire logic [W-1:0] wdata,
  input  wire logic         rd,
  output logic              q_empty,
  output logic [W-1:0]      rdata
);
  logic [W-1:0] slot [2];
  logic         wp, rp;
  logic [1:0]   fill;

  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);
  assign rdata   = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr && !q_full) wp <= !wp;
      if (rd && !q_empty) rp <= !rp;
      fill <= fill + 2'(wr && !q_full) - 2'(rd && !q_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !q_full) slot[wp] <= wdata;
  end
endmodule
`default_nettype wire

FILE: src/chfi_back.sv
// Back part: walks the bucket chain, inserts on a miss, holds the result.
// Depends on chfi_pkg and chained_hash_find_or_insert_assert.svh.
`default_nettype none
`include "chained_hash_find_or_insert_assert.svh"
module chfi_back #(
  parameter int BUCKETS = 256,
  parameter int POOL_ENTRIES = 1024,
  parameter int HW = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  input  wire logic [HW+chfi_pkg::CODE_W:0] q_data,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [9:0]                        entry_index,
  output logic [7:0]                        bucket,
  output logic [10:0]                       probes,
  output logic                              inserted,
  output logic                              full_res
);
  import chfi_pkg::*;
  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);

  back_state_t       state, state_next;
  logic [CODE_W-1:0] keys  [POOL_ENTRIES];
  logic [PW:0]       links [POOL_ENTRIES];
  logic [PW-1:0]     heads [BUCKETS];
  logic [BUCKETS-1:0] head_valid;
  logic [CODE_W-1:0] key_rd, code;
  logic [PW:0]       link_rd;
  logic [PW-1:0]     head_rd, idx, idx_next, res, res_next;
  logic [HW-1:0]     bkt, rd_bkt;
  logic              clr, valid, valid_next, ins, ins_next, fl, fl_next, out_valid;
  logic [CW-1:0]     used, used_next, prb, prb_next;
  logic              do_ins, head_clear, load_out;
  logic              q_clr;
  logic [CODE_W-1:0] q_code;
  logic [HW-1:0]     q_bkt;

  assign {q_clr, q_code, q_bkt} = q_data;
  assign rd_bkt = (state == B_IDLE) ? q_bkt : bkt;
  assign empty = !out_valid;

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    idx_next = idx;
    valid_next = valid;
    prb_next = prb;
    res_next = res;
    ins_next = ins;
    fl_next = fl;
    used_next = used;
    do_ins = 1'b0;
    head_clear = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        prb_next = '0;
        res_next = '0;
        ins_next = 1'b0;
        fl_next = 1'b0;
        if (q_clr) begin
          head_clear = 1'b1;
          used_next = '0;
          state_next = B_DONE;
        end else begin
          state_next = B_HEAD;
        end
      end
      B_HEAD: begin
        idx_next = head_rd;
        valid_next = head_valid[bkt];
        state_next = B_READ;
      end
      B_READ: begin
        if (valid && CW'(idx) < used && prb < CW'(POOL_ENTRIES)) begin
          state_next = B_CMP;
        end else begin
          state_next = B_DONE;
          if (used >= CW'(POOL_ENTRIES)) begin
            fl_next = 1'b1;
            res_next = '0;
          end else begin
            do_ins = 1'b1;
            res_next = PW'(used);
            ins_next = 1'b1;
            used_next = used + CW'(1);
          end
        end
      end
      B_CMP: begin
        prb_next = prb + CW'(1);
        if (key_rd == code) begin
          res_next = idx;
          state_next = B_DONE;
        end else begin
          idx_next = link_rd[PW-1:0];
          valid_next = link_rd[PW];
          state_next = B_READ;
        end
      end
      B_DONE: if (!out_valid || pop) begin
        load_out = 1'b1;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      head_valid <= '0;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      if (head_clear) begin
        head_valid <= '0;
      end else if (do_ins) begin
        head_valid[bkt] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    valid <= valid_next;
    prb <= prb_next;
    res <= res_next;
    ins <= ins_next;
    fl <= fl_next;
    if (q_pop) begin
      clr <= q_clr;
      code <= q_code;
      bkt <= q_clr ? '0 : q_bkt;
    end
    if (load_out) begin
      entry_index <= 10'(res);
      bucket <= clr ? 8'd0 : 8'(bkt);
      probes <= 11'(prb);
      inserted <= ins;
      full_res <= fl;
    end
  end

  // Node pool and bucket heads, each with a registered read port.
  always_ff @(posedge clk) begin
    key_rd <= keys[idx];
    link_rd <= links[idx];
    head_rd <= heads[rd_bkt];
    if (do_ins) begin
      keys[PW'(used)] <= code;
      links[PW'(used)] <= {head_valid[bkt], head_rd};
      heads[bkt] <= PW'(used);
    end
  end

  `CHFI_ASSERT_NOW(a_used_bound, clk, rst, 1'b1, used <= CW'(POOL_ENTRIES))
  `CHFI_ASSERT_NEXT(a_clear_empties, clk, rst, head_clear, used == '0 && head_valid == '0)
  `CHFI_ASSERT_NOW(a_probe_bound, clk, rst, state == B_CMP, prb < CW'(POOL_ENTRIES))
endmodule
`default_nettype wire

FILE: src/chained_hash_find_or_insert.sv
// Top level of the chained hash find-or-insert table.
// Depends on chfi_pkg, chfi_front, chfi_queue and chfi_back.
//
// Input channel: an item (kind, char_code) is taken when push is high and
// full is low. kind 0 finds char_code in its bucket's chain or inserts it;
// kind 1 empties every bucket and releases the whole node pool.
// Result channel: while empty is low the oldest result sits on entry_index,
// bucket, probes, inserted and full_res; it is taken when pop is high.
// The front part takes one item at a time: it accepts it, works out the
// modulo four quotient bits a cycle, then hands the item to a two-entry
// queue, waiting there while the queue is full. The back part reads the
// bucket head (B_IDLE, B_HEAD), then for each stored key compared passes
// through a memory read (B_READ) and a compare (B_CMP), and loads the result
// register in B_DONE. The two parts overlap.
// bucket_count may be written with bucket_count_we while the block is idle;
// zero acts as one and values above BUCKETS act as BUCKETS.
// Reset empties all buckets and the pool and sets bucket_count to 256.
// When the receiver stalls the result register holds, the back part stops,
// the queue fills and full then holds off new items.
`default_nettype none
module chained_hash_find_or_insert #(
  parameter int BUCKETS = chfi_pkg::DEF_BUCKETS,
  parameter int POOL_ENTRIES = chfi_pkg::DEF_POOL_ENTRIES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        kind,
  input  wire logic [chfi_pkg::CODE_W-1:0] char_code,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [9:0]                       entry_index,
  output logic [7:0]                       bucket,
  output logic [10:0]                      probes,
  output logic                             inserted,
  output logic                             full_res,
  input  wire logic                        bucket_count_we,
  input  wire logic [chfi_pkg::CFG_W-1:0]  bucket_count
);
  import chfi_pkg::*;
  // Bucket index width.
  localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = HW + CODE_W + 1;

  logic [CFG_W-1:0] bucket_count_reg;
  logic             q_push, q_full, q_empty, q_pop;
  logic [QW-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count_reg <= BUCKET_COUNT_RESET;
    end else if (bucket_count_we) begin
      bucket_count_reg <= bucket_count;
    end
  end

  chfi_front #(.BUCKETS(BUCKETS), .HW(HW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .char_code(char_code), .bucket_count(bucket_count_reg),
    .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
  );

  chfi_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .q_full(q_full), .wdata(q_wdata),
    .rd(q_pop), .q_empty(q_empty), .rdata(q_rdata)
  );

  chfi_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .HW(HW)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .empty(empty), .pop(pop), .entry_index(entry_index), .bucket(bucket),
    .probes(probes), .inserted(inserted), .full_res(full_res)
  );
endmodule
`default_nettype wire
